>>> design/wlq_pkg.sv
`default_nettype none
package wlq_pkg;

  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned WIDTH_W    = 31;
  localparam int unsigned BASE_W     = 16;
  localparam int unsigned IN_DATA_W  = 4 * COORD_W;
  localparam int unsigned OUT_DATA_W = 8 * COORD_W + BASE_W;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 31'd65536;

  // Clamp a 34-bit signed sum to the int32 range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [33:0] v);
    logic [COORD_W-1:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/wide_line_segment_to_quad_top.sv
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tdata: start_x,start_y,end_x,end_y; tlast: last_segment
// out_    | out | out_tvalid/tready  | tdata: 8 corner coordinates, base_index
// cfg_    | in  | cfg_valid/ready    | cfg_data: line_width
//
// A segment passes from its input transfer to its result through normalization (up to 30
// one-bit shifts plus a final check), two squarings and a sum, 32 square-root steps, two
// divisions of one setup and 31 steps each, and the offset/output states S_OFFX, S_OFFY,
// S_OFFE and S_OUT; a zero-length segment goes straight to the offset states. The
// square-root and division steps share one subtractor and all products one multiplier.
// Reset (rst_n low, synchronous) clears the vertex counter, sets line_width to 1.0.
// A finished result waits in the output register; a new segment is accepted
// meanwhile, and its result is held back until the previous one is taken.
`default_nettype none
module wide_line_segment_to_quad_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96]
  input  wire logic [wlq_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // start_minus_x, start_minus_y, start_plus_x, start_plus_y, end_minus_x,
  // end_minus_y, end_plus_x, end_plus_y (32 each), base_index[271:256]
  output logic [wlq_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [wlq_pkg::WIDTH_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQX, S_SQY, S_SUM, S_ROOT,
    S_DSETX, S_DIVX, S_DSETY, S_DIVY, S_OFFX, S_OFFY, S_OFFE, S_OUT
  } state_t;

  state_t state_r;
  logic [wlq_pkg::WIDTH_W-1:0]    width_r;
  logic [wlq_pkg::INDEX_BITS-1:0] count_r;
  logic                           out_valid_r;
  logic [wlq_pkg::OUT_DATA_W-1:0] out_data_r;

  logic signed [31:0] sx_r, sy_r, ex_r, ey_r;
  logic               last_r, dxpos_r, dyneg_r;
  logic [32:0]        mx_r, my_r;
  logic [61:0]        prod_r;
  logic [63:0]        acc_r, res_r, bit_r;
  logic [62:0]        rem_r, dsr_r;
  logic [30:0]        q_r, qx_r, qy_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] ox_r, oy_r;

  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady, mmax;
  logic [30:0]        mul_a, mul_b;
  logic [63:0]        root_try;
  logic [63:0]        sub_a, sub_b, sub_d;
  logic               sub_ge;
  logic [31:0]        o_mag;
  logic               out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Difference and magnitudes of the incoming segment
  assign dx  = 33'(signed'(in_tdata[95:64])) - 33'(signed'(in_tdata[31:0]));
  assign dy  = 33'(signed'(in_tdata[127:96])) - 33'(signed'(in_tdata[63:32]));
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign mmax = (mx_r > my_r) ? mx_r : my_r;

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      S_SQX:   begin mul_a = mx_r[30:0]; mul_b = mx_r[30:0]; end
      S_SQY:   begin mul_a = my_r[30:0]; mul_b = my_r[30:0]; end
      S_OFFX:  begin mul_a = qy_r;       mul_b = width_r;    end
      default: begin mul_a = qx_r;       mul_b = width_r;    end
    endcase
  end

  // Shared compare/subtract for square-root and division steps
  assign root_try = res_r + bit_r;
  assign sub_a    = (state_r == S_ROOT) ? acc_r : 64'(rem_r);
  assign sub_b    = (state_r == S_ROOT) ? root_try : 64'(dsr_r);
  assign sub_ge   = (sub_a >= sub_b);
  assign sub_d    = sub_a - sub_b;

  assign o_mag    = 32'((63'(prod_r) + 63'h4000_0000) >> 31);

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= wlq_pkg::WIDTH_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        width_r <= cfg_data;
      end
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            sx_r    <= in_tdata[31:0];
            sy_r    <= in_tdata[63:32];
            ex_r    <= in_tdata[95:64];
            ey_r    <= in_tdata[127:96];
            last_r  <= in_tlast;
            dxpos_r <= !dx[32] && (dx != '0);
            dyneg_r <= dy[32];
            mx_r    <= adx;
            my_r    <= ady;
            qx_r    <= '0;
            qy_r    <= '0;
            state_r <= ((adx | ady) == '0) ? S_OFFX : S_NORM;
          end
        end
        // Shift magnitudes until the larger lies in [2^30, 2^31)
        S_NORM: begin
          if (mmax[32:31] != 2'b00) begin
            mx_r <= mx_r >> 1;
            my_r <= my_r >> 1;
          end else if (!mmax[30]) begin
            mx_r <= mx_r << 1;
            my_r <= my_r << 1;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_SQY;
        end
        S_SQY: begin
          acc_r   <= 64'(prod_r);
          prod_r  <= mul_a * mul_b;
          state_r <= S_SUM;
        end
        S_SUM: begin
          acc_r   <= acc_r + 64'(prod_r);
          res_r   <= '0;
          bit_r   <= 64'h4000_0000_0000_0000;
          state_r <= S_ROOT;
        end
        // One square-root digit per cycle
        S_ROOT: begin
          if (sub_ge) begin
            acc_r <= sub_d;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 64'd1) begin
            state_r <= S_DSETX;
          end
        end
        S_DSETX, S_DSETY: begin
          rem_r   <= 63'({(state_r == S_DSETX) ? mx_r[30:0] : my_r[30:0], 30'b0})
                     + 63'(res_r[31:1]);
          dsr_r   <= 63'({res_r[31:0], 30'b0});
          q_r     <= '0;
          cnt_r   <= 5'd30;
          state_r <= (state_r == S_DSETX) ? S_DIVX : S_DIVY;
        end
        // One quotient bit per cycle
        S_DIVX, S_DIVY: begin
          if (sub_ge) begin
            rem_r <= sub_d[62:0];
            q_r   <= {q_r[29:0], 1'b1};
          end else begin
            q_r   <= {q_r[29:0], 1'b0};
          end
          dsr_r <= dsr_r >> 1;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == '0) begin
            state_r <= (state_r == S_DIVX) ? S_DSETY : S_OFFX;
          end
        end
        S_OFFX: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_OFFY;
        end
        S_OFFY: begin
          ox_r    <= dyneg_r ? -signed'(o_mag) : signed'(o_mag);
          prod_r  <= mul_a * mul_b;
          state_r <= S_OFFE;
        end
        S_OFFE: begin
          oy_r    <= dxpos_r ? -signed'(o_mag) : signed'(o_mag);
          state_r <= S_OUT;
        end
        // Form corners once the output register is free
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {
              wlq_pkg::BASE_W'(count_r),
              wlq_pkg::sat32(34'(ey_r) + 34'(oy_r)),
              wlq_pkg::sat32(34'(ex_r) + 34'(ox_r)),
              wlq_pkg::sat32(34'(ey_r) - 34'(oy_r)),
              wlq_pkg::sat32(34'(ex_r) - 34'(ox_r)),
              wlq_pkg::sat32(34'(sy_r) + 34'(oy_r)),
              wlq_pkg::sat32(34'(sx_r) + 34'(ox_r)),
              wlq_pkg::sat32(34'(sy_r) - 34'(oy_r)),
              wlq_pkg::sat32(34'(sx_r) - 34'(ox_r))
            };
            count_r <= last_r ? '0 : count_r + wlq_pkg::INDEX_BITS'(4);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Capture quotients at the end of each division
      if (state_r == S_DIVX && cnt_r == '0) begin
        qx_r <= sub_ge ? {q_r[29:0], 1'b1} : {q_r[29:0], 1'b0};
      end
      if (state_r == S_DIVY && cnt_r == '0) begin
        qy_r <= sub_ge ? {q_r[29:0], 1'b1} : {q_r[29:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> design/wlq_checker.sv
`default_nettype none
module wlq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [wlq_pkg::OUT_DATA_W-1:0] out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Busy after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // No result in the cycle after an input transfer
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // Reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind wide_line_segment_to_quad_top wlq_checker u_wlq_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

>>> dv/wide_line_segment_to_quad_top_tb.sv
`default_nettype none
module wide_line_segment_to_quad_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 300;

  // Field order matches out_tdata: base_index on top, start_minus_x lowest
  typedef struct packed {
    logic [wlq_pkg::BASE_W-1:0]  base;
    logic [wlq_pkg::COORD_W-1:0] epy, epx, emy, emx, spy, spx, smy, smx;
  } quad_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [wlq_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [wlq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [wlq_pkg::WIDTH_W-1:0]    cfg_data;

  wide_line_segment_to_quad_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the block state
  logic [wlq_pkg::WIDTH_W-1:0]    width_q;
  logic [wlq_pkg::INDEX_BITS-1:0] vtx_count;
  quad_t                          quad_queue[$];
  int                             fail_count;
  int                             idle_cycles;
  int                             send_idle_pct;
  int                             recv_idle_pct;
  bit                             recv_hold;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint half_width_offset(input longint p);
    logic [63:0] m, o;
    m = (p < 0) ? -p : p;
    o = (m * {33'd0, width_q} + (64'd1 << 30)) >> 31;
    return (p < 0) ? -longint'(o) : longint'(o);
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Compute the expected quad and advance the vertex counter
  function automatic quad_t predict_quad(input logic [31:0] sx_b, sy_b, ex_b, ey_b,
                                         input logic last);
    quad_t q;
    longint sx, sy, ex, ey, dx, dy, ux, uy, ox, oy;
    logic [63:0] mx, my, mmax, len, qx, qy;
    sx = longint'(signed'(sx_b)); sy = longint'(signed'(sy_b));
    ex = longint'(signed'(ex_b)); ey = longint'(signed'(ey_b));
    dx = ex - sx; dy = ey - sy;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    mmax = (mx > my) ? mx : my;
    ux = 0; uy = 0;
    if (mmax != 0) begin
      while (mmax >= (64'd1 << 31)) begin
        mx = mx >> 1; my = my >> 1; mmax = mmax >> 1;
      end
      while (mmax < (64'd1 << 30)) begin
        mx = mx << 1; my = my << 1; mmax = mmax << 1;
      end
      len = isqrt(mx * mx + my * my);
      qx = ((mx << 30) + (len >> 1)) / len;
      qy = ((my << 30) + (len >> 1)) / len;
      if (qx > (64'd1 << 30)) qx = 64'd1 << 30;
      if (qy > (64'd1 << 30)) qy = 64'd1 << 30;
      ux = (dx < 0) ? -longint'(qx) : longint'(qx);
      uy = (dy < 0) ? -longint'(qy) : longint'(qy);
    end
    ox = half_width_offset(uy);
    oy = half_width_offset(-ux);
    q.smx = clamp32(sx - ox); q.smy = clamp32(sy - oy);
    q.spx = clamp32(sx + ox); q.spy = clamp32(sy + oy);
    q.emx = clamp32(ex - ox); q.emy = clamp32(ey - oy);
    q.epx = clamp32(ex + ox); q.epy = clamp32(ey + oy);
    q.base = vtx_count[wlq_pkg::BASE_W-1:0];
    vtx_count = last ? '0 : vtx_count + wlq_pkg::INDEX_BITS'(4);
    return q;
  endfunction

  // Offer one segment, predict on transfer, then drop valid
  task automatic send_segment(input logic [31:0] sx, sy, ex, ey, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {ey, ex, sy, sx};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    quad_queue.push_back(predict_quad(sx, sy, ex, ey, last));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (quad_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [wlq_pkg::WIDTH_W-1:0] w);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_q = w;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF - $urandom_range(3);
      1:       return 32'h8000_0000 + $urandom_range(3);
      2:       return $urandom_range(2000) - 1000;
      3:       return ($urandom_range(200000) - 100000) << 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [31:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = rand_coord();
      sy = rand_coord();
      if ($urandom_range(15) == 0) send_segment(sx, sy, sx, sy, $urandom_range(7) == 0);
      else send_segment(sx, sy, rand_coord(), rand_coord(), $urandom_range(7) == 0);
    end
  endtask

  task automatic test_directed();
    send_segment(0, 0, 32'h0001_0000, 0, 1'b0);
    send_segment(0, 0, 0, 32'h0001_0000, 1'b0);
    send_segment(32'h0001_0000, 32'h0001_0000, 0, 0, 1'b0);
    send_segment(32'h1234_5678, 32'hF000_0000, 32'h1234_5678, 32'hF000_0000, 1'b0);
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_segment(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_segment(32'h8000_0000, 5, 32'h8000_0001, 5, 1'b0);
    send_segment(0, 0, 1, 1, 1'b1);
    send_segment(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_width_sweep();
    write_width('0);
    send_random(60);
    write_width(31'h7FFF_FFFF);
    test_directed();
    send_random(60);
    write_width(31'd1);
    send_random(40);
    write_width(31'd3 << 16);
  endtask

  // Hold the sink for a long stretch while segments keep coming
  task automatic test_backpressure();
    wait_drained();
    recv_hold = 1'b1;
    fork
      send_random(6);
      begin
        repeat (1500) @(posedge clk);
        recv_hold = 1'b0;
      end
    join
    wait_drained();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 30; recv_idle_pct = 78;
    send_random(280);
    send_idle_pct = 78; recv_idle_pct = 30;
    send_random(280);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(280);
  endtask

  // Long list without a last marker
  task automatic test_long_list();
    for (int i = 0; i < 80; i++) begin
      send_segment($urandom, $urandom, $urandom, $urandom, 1'b0);
    end
  endtask

  // Sink readiness
  always @(posedge clk) begin
    if (recv_hold) out_tready <= 1'b0;
    else out_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    quad_t got, exp_q;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (quad_queue.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        fail_count++;
      end else begin
        exp_q = quad_queue.pop_front();
        if (got.smx !== exp_q.smx) begin
          $error("start_minus_x exp %h got %h", exp_q.smx, got.smx); fail_count++;
        end
        if (got.smy !== exp_q.smy) begin
          $error("start_minus_y exp %h got %h", exp_q.smy, got.smy); fail_count++;
        end
        if (got.spx !== exp_q.spx) begin
          $error("start_plus_x exp %h got %h", exp_q.spx, got.spx); fail_count++;
        end
        if (got.spy !== exp_q.spy) begin
          $error("start_plus_y exp %h got %h", exp_q.spy, got.spy); fail_count++;
        end
        if (got.emx !== exp_q.emx) begin
          $error("end_minus_x exp %h got %h", exp_q.emx, got.emx); fail_count++;
        end
        if (got.emy !== exp_q.emy) begin
          $error("end_minus_y exp %h got %h", exp_q.emy, got.emy); fail_count++;
        end
        if (got.epx !== exp_q.epx) begin
          $error("end_plus_x exp %h got %h", exp_q.epx, got.epx); fail_count++;
        end
        if (got.epy !== exp_q.epy) begin
          $error("end_plus_y exp %h got %h", exp_q.epy, got.epy); fail_count++;
        end
        if (got.base !== exp_q.base) begin
          $error("base_index exp %h got %h", exp_q.base, got.base); fail_count++;
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("wide_line_segment_to_quad_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    out_tready = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    fail_count = 0; idle_cycles = 0; recv_hold = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0;
    width_q = wlq_pkg::WIDTH_RESET; vtx_count = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_width_sweep();
    test_backpressure();
    test_random_traffic();
    test_long_list();
    wait_drained();
    if (fail_count == 0) begin
      $display("wide_line_segment_to_quad_top: match");
    end else begin
      $display("wide_line_segment_to_quad_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
